@@ hw/rtl/rotated_sorted_table_search_macros.svh @@
// Assertion macros shared by the rotated sorted table search RTL.
`ifndef ROTATED_SORTED_TABLE_SEARCH_MACROS_SVH
`define ROTATED_SORTED_TABLE_SEARCH_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define RSTS_ASSERT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rsts assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define RSTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rsts assertion failed");
`else
`define RSTS_ASSERT(label, clk, rst_n, ante, cons)
`define RSTS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ hw/rtl/rsts_pkg.sv @@
// Shared constants, microcode types and control program of the rotated table search.
package rsts_pkg;

    localparam int DEPTH_DEF       = 1024;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam int IN_WIDTH    = 32;
    localparam int SIZE_WIDTH  = 11;
    localparam int ROT_WIDTH   = 10;
    localparam int POS_WIDTH   = 10;
    localparam int LCNT_WIDTH  = 10;
    localparam int CFG_WIDTH   = 11;
    localparam int CIDX_WIDTH  = 1;

    localparam logic [SIZE_WIDTH-1:0] TABLE_SIZE_RESET = 11'd1024;

    localparam logic [CIDX_WIDTH-1:0] REG_TABLE_SIZE = 1'd0;
    localparam logic [CIDX_WIDTH-1:0] REG_ROTATE_BY  = 1'd1;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    typedef logic [3:0] step_t;

    localparam step_t STEP_IDLE   = 4'd0;
    localparam step_t STEP_DISP   = 4'd1;
    localparam step_t STEP_RDLAST = 4'd2;
    localparam step_t STEP_SEG    = 4'd3;
    localparam step_t STEP_FULL   = 4'd4;
    localparam step_t STEP_OPEN   = 4'd5;
    localparam step_t STEP_PROBE  = 4'd6;
    localparam step_t STEP_DONE   = 4'd7;
    localparam step_t STEP_LOAD   = 4'd8;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_RD_LAST,
        ACT_SEG,
        ACT_FULL,
        ACT_OPEN,
        ACT_PROBE,
        ACT_EMIT,
        ACT_WRITE
    } act_t;

    typedef enum logic [2:0] {
        COND_ALWAYS,
        COND_NOT_START,
        COND_IS_LOAD,
        COND_K_ZERO,
        COND_EMPTY,
        COND_STOP
    } cond_t;

    // One control word: datapath action, branch condition, taken and fall-through steps.
    typedef struct packed {
        act_t  act;
        cond_t cond;
        step_t jmp;
        step_t nxt;
    } uword_t;

    // Status from the datapath that the sequencer branches on.
    typedef struct packed {
        logic start;
        logic is_load;
        logic k_zero;
        logic empty;
        logic stop;
    } flags_t;

    function automatic uword_t ucode(input step_t s);
        uword_t w;
        begin
            unique case (s)
                STEP_IDLE:   w = '{ACT_NONE,    COND_NOT_START, STEP_IDLE,  STEP_DISP};
                STEP_DISP:   w = '{ACT_NONE,    COND_IS_LOAD,   STEP_LOAD,  STEP_RDLAST};
                STEP_RDLAST: w = '{ACT_RD_LAST, COND_K_ZERO,    STEP_FULL,  STEP_SEG};
                STEP_SEG:    w = '{ACT_SEG,     COND_ALWAYS,    STEP_OPEN,  STEP_OPEN};
                STEP_FULL:   w = '{ACT_FULL,    COND_ALWAYS,    STEP_OPEN,  STEP_OPEN};
                STEP_OPEN:   w = '{ACT_OPEN,    COND_EMPTY,     STEP_DONE,  STEP_PROBE};
                STEP_PROBE:  w = '{ACT_PROBE,   COND_STOP,      STEP_DONE,  STEP_PROBE};
                STEP_DONE:   w = '{ACT_EMIT,    COND_ALWAYS,    STEP_IDLE,  STEP_IDLE};
                STEP_LOAD:   w = '{ACT_WRITE,   COND_ALWAYS,    STEP_IDLE,  STEP_IDLE};
                default:     w = '{ACT_NONE,    COND_ALWAYS,    STEP_IDLE,  STEP_IDLE};
            endcase
            return w;
        end
    endfunction

endpackage

@@ hw/rtl/rsts_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module rsts_ram #(
    parameter int WIDTH = rsts_pkg::VALUE_WIDTH_DEF,
    parameter int DEPTH = rsts_pkg::DEPTH_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/rsts_seq.sv @@
// Microcode sequencer: step counter, control store and conditional branch.
module rsts_seq (
    input  logic              clk,
    input  logic              rst_n,
    input  rsts_pkg::flags_t  flags,
    output rsts_pkg::uword_t  uword,
    output logic              busy
);

    rsts_pkg::step_t pc_reg;
    rsts_pkg::step_t pc_next;
    logic            take;

    assign uword = rsts_pkg::ucode(pc_reg);
    assign busy  = (pc_reg != rsts_pkg::STEP_IDLE);

    always_comb
    begin
        unique case (uword.cond)
            rsts_pkg::COND_ALWAYS:    take = 1'b1;
            rsts_pkg::COND_NOT_START: take = !flags.start;
            rsts_pkg::COND_IS_LOAD:   take = flags.is_load;
            rsts_pkg::COND_K_ZERO:    take = flags.k_zero;
            rsts_pkg::COND_EMPTY:     take = flags.empty;
            rsts_pkg::COND_STOP:      take = flags.stop;
            default:                  take = 1'b1;
        endcase
        pc_next = take ? uword.jmp : uword.nxt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= rsts_pkg::STEP_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

@@ hw/rtl/rotated_sorted_table_search.sv @@
// Top level of the rotated sorted table search: datapath, config registers, table RAM.
//
// Usage: a transaction is taken at a rising edge with start high and busy low.
// op 0 loads the next sorted value into the table at its rotated position;
// op 1 searches for value. Loads give no result. A search result appears on
// found/position for exactly one cycle, marked by done; the receiver cannot
// stall it, so it must take the result in that cycle.
// Configuration: cfg_we with cfg_index 0 writes table_size, 1 writes rotate_by.
// Write only while busy is low and no transaction is in flight.
// Timing: a load keeps busy high through the dispatch and write steps. A search
// keeps busy high through dispatch, last-entry read, range setup, open, p table
// probes and the result step, and raises done in the last of them, where p is at
// most ceil(log2(n+1)). The RAM's registered read port sets one probe per cycle.
// Reset: the sequencer idles, the load counter clears, table_size returns to
// 1024 and rotate_by to 0. Table contents are undefined until loaded.
`include "rotated_sorted_table_search_macros.svh"

module rotated_sorted_table_search #(
    parameter int DEPTH       = rsts_pkg::DEPTH_DEF,
    parameter int VALUE_WIDTH = rsts_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 op,
    input  logic signed [rsts_pkg::IN_WIDTH-1:0] value,
    output logic                                 done,
    output logic                                 found,
    output logic [rsts_pkg::POS_WIDTH-1:0]       position,
    input  logic                                 cfg_we,
    input  logic [rsts_pkg::CIDX_WIDTH-1:0]      cfg_index,
    input  logic [rsts_pkg::CFG_WIDTH-1:0]       cfg_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int NW = AW + 1;

    // control and configuration state
    logic [rsts_pkg::SIZE_WIDTH-1:0] table_size_reg;
    logic [rsts_pkg::ROT_WIDTH-1:0]  rotate_by_reg;
    logic [rsts_pkg::LCNT_WIDTH-1:0] load_cnt_reg;
    logic [rsts_pkg::LCNT_WIDTH-1:0] load_cnt_next;

    // transaction payload and search state
    logic                   op_reg;
    logic [VALUE_WIDTH-1:0] key_reg;
    logic [VALUE_WIDTH-1:0] key_next;
    logic [NW-1:0]          lo_reg;
    logic [NW-1:0]          lo_next;
    logic [NW-1:0]          hi_reg;
    logic [NW-1:0]          hi_next;
    logic [AW-1:0]          mid_reg;
    logic [AW-1:0]          mid_next;
    logic                   found_reg;
    logic                   found_next;
    logic [AW-1:0]          pos_reg;
    logic [AW-1:0]          pos_next;

    logic                   accept;
    rsts_pkg::uword_t       uword;
    rsts_pkg::flags_t       flags;

    logic [NW-1:0]          n_eff;
    logic [NW-1:0]          k_eff;
    logic [NW-1:0]          ld_idx;
    logic [NW-1:0]          ld_inc;
    logic [NW-1:0]          ld_pos;
    logic [63:0]            val_ext;

    logic [NW:0]            sum_open;
    logic [AW-1:0]          mid_open;
    logic                   hit;
    logic                   key_below;
    logic [NW-1:0]          lo_probe;
    logic [NW-1:0]          hi_probe;
    logic [NW:0]            sum_probe;
    logic [AW-1:0]          mid_probe;
    logic [NW-1:0]          n_last;

    logic                   ram_we;
    logic [AW-1:0]          ram_raddr;
    logic [VALUE_WIDTH-1:0] ram_rdata;

    assign accept = start && !busy;

    // effective size and rotation
    always_comb
    begin
        if (table_size_reg == '0)
        begin
            n_eff = NW'(1);
        end
        else if (32'(table_size_reg) > 32'(DEPTH))
        begin
            n_eff = NW'(DEPTH);
        end
        else
        begin
            n_eff = NW'(table_size_reg);
        end
        k_eff  = (32'(rotate_by_reg) < 32'(n_eff)) ? NW'(rotate_by_reg) : '0;
        n_last = n_eff - NW'(1);
    end

    // load position: sorted index i lands at (i - k) mod n
    always_comb
    begin
        ld_idx        = (32'(load_cnt_reg) < 32'(n_eff)) ? NW'(load_cnt_reg) : '0;
        ld_inc        = ld_idx + NW'(1);
        ld_pos        = (ld_idx >= k_eff) ? (ld_idx - k_eff) : (ld_idx + n_eff - k_eff);
        load_cnt_next = (ld_inc == n_eff) ? '0 : rsts_pkg::LCNT_WIDTH'(ld_inc);
    end

    // flipping the sign bit makes unsigned order match signed order
    assign val_ext  = {{(64 - rsts_pkg::IN_WIDTH){value[rsts_pkg::IN_WIDTH-1]}}, value};
    assign key_next = {~val_ext[VALUE_WIDTH-1], val_ext[VALUE_WIDTH-2:0]};

    // probe arithmetic
    always_comb
    begin
        sum_open  = (NW+1)'(lo_reg) + (NW+1)'(hi_reg);
        mid_open  = sum_open[AW:1];
        hit       = (ram_rdata == key_reg);
        key_below = (ram_rdata > key_reg);
        lo_probe  = key_below ? lo_reg : (NW'(mid_reg) + NW'(1));
        hi_probe  = key_below ? NW'(mid_reg) : hi_reg;
        sum_probe = (NW+1)'(lo_probe) + (NW+1)'(hi_probe);
        mid_probe = sum_probe[AW:1];
    end

    assign flags.start   = start;
    assign flags.is_load = (op_reg == rsts_pkg::OP_LOAD);
    assign flags.k_zero  = (k_eff == '0);
    assign flags.empty   = (lo_reg >= hi_reg);
    assign flags.stop    = hit || (lo_probe >= hi_probe);

    // datapath actions under the current control word
    always_comb
    begin
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mid_next   = mid_reg;
        found_next = found_reg;
        pos_next   = pos_reg;
        ram_raddr  = mid_reg;
        ram_we     = 1'b0;
        case (uword.act)
            rsts_pkg::ACT_RD_LAST:
            begin
                ram_raddr = n_last[AW-1:0];
            end
            rsts_pkg::ACT_SEG:
            begin
                // read data holds the last entry here
                if (key_reg > ram_rdata)
                begin
                    lo_next = '0;
                    hi_next = n_eff - k_eff;
                end
                else
                begin
                    lo_next = n_eff - k_eff;
                    hi_next = n_eff;
                end
            end
            rsts_pkg::ACT_FULL:
            begin
                lo_next = '0;
                hi_next = n_eff;
            end
            rsts_pkg::ACT_OPEN:
            begin
                found_next = 1'b0;
                pos_next   = '0;
                mid_next   = mid_open;
                ram_raddr  = mid_open;
            end
            rsts_pkg::ACT_PROBE:
            begin
                if (hit)
                begin
                    found_next = 1'b1;
                    pos_next   = mid_reg;
                end
                else
                begin
                    lo_next   = lo_probe;
                    hi_next   = hi_probe;
                    mid_next  = mid_probe;
                    ram_raddr = mid_probe;
                end
            end
            rsts_pkg::ACT_WRITE:
            begin
                ram_we = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_size_reg <= rsts_pkg::TABLE_SIZE_RESET;
            rotate_by_reg  <= '0;
            load_cnt_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    rsts_pkg::REG_TABLE_SIZE:
                        table_size_reg <= cfg_data[rsts_pkg::SIZE_WIDTH-1:0];
                    rsts_pkg::REG_ROTATE_BY:
                        rotate_by_reg <= cfg_data[rsts_pkg::ROT_WIDTH-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (uword.act == rsts_pkg::ACT_WRITE)
            begin
                load_cnt_reg <= load_cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= op;
            key_reg <= key_next;
        end
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        mid_reg   <= mid_next;
        found_reg <= found_next;
        pos_reg   <= pos_next;
    end

    rsts_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .uword (uword),
        .busy  (busy)
    );

    rsts_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ld_pos[AW-1:0]),
        .wdata (key_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign done     = (uword.act == rsts_pkg::ACT_EMIT);
    assign found    = found_reg;
    assign position = rsts_pkg::POS_WIDTH'(pos_reg);

    `RSTS_ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, busy)
    `RSTS_ASSERT_NEXT(a_load_silent, clk, rst_n, accept && (op == rsts_pkg::OP_LOAD), !done ##1 !done ##1 !busy)
    `RSTS_ASSERT(a_probe_range, clk, rst_n, uword.act == rsts_pkg::ACT_PROBE, (lo_reg < hi_reg) && (hi_reg <= n_eff))
    `RSTS_ASSERT(a_miss_pos, clk, rst_n, done && !found, position == '0)
    `RSTS_ASSERT(a_done_busy, clk, rst_n, done, busy && (op_reg == rsts_pkg::OP_SEARCH))

endmodule

@@ test/rsts_search_checker.sv @@
// Checker for the rotated sorted table search: tracks table state, predicts lookups, compares.
`timescale 1ns / 1ps

module rsts_search_checker
    import rsts_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic                         busy,
    input  logic                         op,
    input  logic signed [IN_WIDTH-1:0]   value,
    input  logic                         done,
    input  logic                         found,
    input  logic [POS_WIDTH-1:0]         position,
    input  logic                         cfg_we,
    input  logic [CIDX_WIDTH-1:0]        cfg_index,
    input  logic [CFG_WIDTH-1:0]         cfg_data,
    output int                           errors,
    output int                           outstanding
);

    typedef struct {
        logic                 hit;
        logic [POS_WIDTH-1:0] pos;
    } lookup_result_t;

    logic signed [IN_WIDTH-1:0] entries [DEPTH_DEF];
    logic [SIZE_WIDTH-1:0]      size_reg;
    logic [ROT_WIDTH-1:0]       rot_reg;
    logic [LCNT_WIDTH-1:0]      next_load;
    lookup_result_t             pending_lookups [$];
    int                         mismatch_count;

    function automatic int unsigned entries_in_use();
        if (size_reg == 0)
            return 1;
        if (size_reg > DEPTH_DEF)
            return DEPTH_DEF;
        return size_reg;
    endfunction

    function automatic int unsigned rotation(int unsigned n);
        return (rot_reg < n) ? rot_reg : 0;
    endfunction

    function automatic void store_entry(logic signed [IN_WIDTH-1:0] v);
        int unsigned n;
        int unsigned k;
        int unsigned i;
        int unsigned p;
        n = entries_in_use();
        k = rotation(n);
        i = (next_load < n) ? next_load : 0;
        p = (i >= k) ? i - k : i + n - k;
        entries[p] = v;
        next_load = (i + 1 == n) ? '0 : LCNT_WIDTH'(i + 1);
    endfunction

    // Picks the run the key must lie in, then bisects it; first probe that matches wins.
    function automatic lookup_result_t predict_lookup(logic signed [IN_WIDTH-1:0] key);
        int unsigned n;
        int unsigned k;
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        lookup_result_t r;
        n = entries_in_use();
        k = rotation(n);
        r.hit = 1'b0;
        r.pos = '0;
        if (k == 0)
        begin
            lo = 0;
            hi = n;
        end
        else if (key > entries[n-1])
        begin
            lo = 0;
            hi = n - k;
        end
        else
        begin
            lo = n - k;
            hi = n;
        end
        while (lo < hi && !r.hit)
        begin
            mid = (lo + hi) / 2;
            if (entries[mid] == key)
            begin
                r.hit = 1'b1;
                r.pos = mid[POS_WIDTH-1:0];
            end
            else if (entries[mid] > key)
                hi = mid;
            else
                lo = mid + 1;
        end
        return r;
    endfunction

    function automatic void report(string what, int unsigned exp_v, int unsigned act_v);
        mismatch_count++;
        $display("%0t %s mismatch: expected %0d, actual %0d", $time, what, exp_v, act_v);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        lookup_result_t exp_r;
        if (!rst_n)
        begin
            size_reg = TABLE_SIZE_RESET;
            rot_reg = '0;
            next_load = '0;
            pending_lookups.delete();
            mismatch_count = 0;
            errors <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_TABLE_SIZE: size_reg = cfg_data[SIZE_WIDTH-1:0];
                    REG_ROTATE_BY:  rot_reg = cfg_data[ROT_WIDTH-1:0];
                endcase
            end
            if (done)
            begin
                if (pending_lookups.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t result with no search pending: %s %0b position %0d",
                             $time, "expected none, actual found", found, position);
                end
                else
                begin
                    exp_r = pending_lookups.pop_front();
                    if (found !== exp_r.hit)
                        report("found", exp_r.hit, found);
                    if (position !== exp_r.pos)
                        report("position", exp_r.pos, position);
                end
            end
            // a transaction is taken when start meets an idle block
            if (start && !busy)
            begin
                if (op == OP_LOAD)
                    store_entry(value);
                else
                    pending_lookups.push_back(predict_lookup(value));
            end
            errors <= mismatch_count;
            outstanding <= pending_lookups.size();
        end
    end

endmodule

@@ test/tb_rotated_sorted_table_search.sv @@
// Testbench top for the rotated sorted table search: stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module tb_rotated_sorted_table_search;
    import rsts_pkg::*;

    localparam int QUIET_LIMIT  = 2000;
    localparam int TARGET_ITEMS = 1700;
    localparam logic signed [IN_WIDTH-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [IN_WIDTH-1:0] VAL_MAX = 32'sh7FFF_FFFF;

    logic                        clk;
    logic                        rst_n;
    logic                        start;
    logic                        busy;
    logic                        op;
    logic signed [IN_WIDTH-1:0]  value;
    logic                        done;
    logic                        found;
    logic [POS_WIDTH-1:0]        position;
    logic                        cfg_we;
    logic [CIDX_WIDTH-1:0]       cfg_index;
    logic [CFG_WIDTH-1:0]        cfg_data;
    int                          errors;
    int                          outstanding;

    int                          sorted_vals [DEPTH_DEF];
    int unsigned                 vals_n;
    int unsigned                 active_n;
    int unsigned                 load_ptr;
    int unsigned                 issued;
    int unsigned                 quiet_cycles;
    bit                          idle_on;

    rotated_sorted_table_search dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .op        (op),
        .value     (value),
        .done      (done),
        .found     (found),
        .position  (position),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    rsts_search_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .op          (op),
        .value       (value),
        .done        (done),
        .found       (found),
        .position    (position),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .errors      (errors),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAIL rotated_sorted_table_search");
            $finish;
        end
    end

    function automatic int unsigned entries_in_use(int unsigned size);
        if (size == 0)
            return 1;
        if (size > DEPTH_DEF)
            return DEPTH_DEF;
        return size;
    endfunction

    // Holds start high across back-to-back transactions; drops it only for an idle gap.
    task automatic issue(logic op_v, logic signed [IN_WIDTH-1:0] v);
        if (idle_on && $urandom_range(0, 99) < 36)
        begin
            // gap counted from the cycle the block is ready again
            start <= 1'b0;
            do
                @(posedge clk);
            while (busy);
            repeat ($urandom_range(0, 1)) @(posedge clk);
        end
        start <= 1'b1;
        op <= op_v;
        value <= v;
        do
            @(posedge clk);
        while (busy);
        issued++;
    endtask

    task automatic load(logic signed [IN_WIDTH-1:0] v);
        int unsigned i;
        i = (load_ptr < active_n) ? load_ptr : 0;
        issue(OP_LOAD, v);
        load_ptr = (i + 1 == active_n) ? 0 : i + 1;
    endtask

    task automatic search(logic signed [IN_WIDTH-1:0] key);
        issue(OP_SEARCH, key);
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0 || busy);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_config(logic [SIZE_WIDTH-1:0] size, logic [ROT_WIDTH-1:0] rot);
        cfg_we <= 1'b1;
        cfg_index <= REG_TABLE_SIZE;
        cfg_data <= size;
        @(posedge clk);
        cfg_index <= REG_ROTATE_BY;
        cfg_data <= CFG_WIDTH'(rot);
        @(posedge clk);
        cfg_we <= 1'b0;
        active_n = entries_in_use(size);
    endtask

    // Ascending values: spread over the full range, tight with duplicates, or saturating.
    function automatic void make_sorted(int unsigned n);
        longint cur;
        longint span;
        int unsigned mode;
        mode = $urandom_range(0, 3);
        cur = (mode == 0) ? -64'sd2147483648 : longint'(int'($urandom));
        case (mode)
            0: span = 64'sd4294967296 / n;
            1: span = $urandom_range(0, 3);
            2: span = (64'sd2147483648 / n) * $urandom_range(1, 2);
            default: span = 64'sd8589934592 / n;
        endcase
        if (span > 64'sd4294967295)
            span = 64'sd4294967295;
        for (int unsigned j = 0; j < n; j++)
        begin
            if (cur > 64'sd2147483647)
                cur = 64'sd2147483647;
            sorted_vals[j] = int'(cur);
            cur += longint'($urandom_range(0, 32'(span)));
        end
        vals_n = n;
    endfunction

    // Loads every entry once, lined up with the load counter so the table stays rotated-sorted.
    task automatic fill(int unsigned n);
        int unsigned i0;
        i0 = (load_ptr < n) ? load_ptr : 0;
        for (int unsigned j = 0; j < n; j++)
            load(sorted_vals[(i0 + j) % n]);
    endtask

    function automatic logic signed [IN_WIDTH-1:0] pick_key();
        int unsigned r;
        int unsigned idx;
        r = $urandom_range(0, 99);
        idx = $urandom_range(0, vals_n - 1);
        if (r < 50)
            return sorted_vals[idx];
        if (r < 65)
            return sorted_vals[idx] + ((r % 2 != 0) ? 1 : -1);
        if (r < 80)
            return $urandom;
        if (r < 88)
            return (r % 2 != 0) ? VAL_MAX : VAL_MIN;
        return (r % 2 != 0) ? sorted_vals[0] - 1 : sorted_vals[vals_n - 1] + 1;
    endfunction

    task automatic random_phase();
        int unsigned r;
        int unsigned sz;
        int unsigned rot;
        int unsigned n;
        int unsigned cnt;
        bit noisy;
        r = $urandom_range(0, 99);
        if (r < 8)
            sz = 0;
        else if (r < 16)
            sz = 1;
        else if (r < 70)
            sz = $urandom_range(2, 40);
        else if (r < 90)
            sz = $urandom_range(41, 200);
        else
            sz = $urandom_range(DEPTH_DEF, 2047);
        n = entries_in_use(sz);
        r = $urandom_range(0, 99);
        if (r < 25)
            rot = 0;
        else if (r < 40 || n == DEPTH_DEF)
            rot = $urandom_range((n > 1023) ? 0 : n, 1023);
        else if (r < 50)
            rot = n - 1;
        else
            rot = $urandom_range(0, n - 1);
        wait_idle();
        set_config(SIZE_WIDTH'(sz), ROT_WIDTH'(rot));
        // full-size phases reuse what is already there: every entry was written earlier
        if (n < DEPTH_DEF)
        begin
            make_sorted(n);
            fill(n);
        end
        noisy = ($urandom_range(0, 9) == 0) || (n == DEPTH_DEF);
        cnt = $urandom_range(n / 2 + 4, 2 * n + 8);
        if (cnt > 60)
            cnt = 60;
        for (int unsigned j = 0; j < cnt; j++)
        begin
            if (noisy && $urandom_range(0, 7) == 0)
                load($urandom);
            search(pick_key());
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        op = OP_LOAD;
        value = '0;
        cfg_we = 1'b0;
        cfg_index = REG_TABLE_SIZE;
        cfg_data = '0;
        active_n = DEPTH_DEF;
        load_ptr = 0;
        vals_n = 1;
        sorted_vals[0] = 0;
        issued = 0;
        quiet_cycles = 0;
        idle_on = 1'b1;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // loads under the reset settings
        load(VAL_MIN);
        load(VAL_MAX);
        // size 0 acts as one entry, oversized rotation acts as none, counter past the end wraps
        wait_idle();
        set_config(0, 5);
        load(7);
        search(7);
        search(8);
        search(VAL_MIN);
        // four entries rotated by one: both runs, both extremes
        wait_idle();
        set_config(4, 1);
        load(VAL_MIN);
        load(-1);
        load(0);
        load(VAL_MAX);
        search(VAL_MIN);
        search(VAL_MAX);
        search(-1);
        search(0);
        search(5);
        search(-2);
        // one load too many overwrites the first sorted slot
        load(1);
        search(1);
        search(0);
        // rotation equal to the size behaves as no rotation
        wait_idle();
        set_config(4, 4);
        search(VAL_MAX);
        search(1);

        // full table at the largest rotation, no idle gaps while it fills
        wait_idle();
        idle_on = 1'b0;
        make_sorted(DEPTH_DEF);
        set_config(2047, 1023);
        fill(DEPTH_DEF);
        for (int j = 0; j < 60; j++)
            search(pick_key());
        wait_idle();
        idle_on = 1'b1;
        set_config(TABLE_SIZE_RESET, 0);
        for (int j = 0; j < 40; j++)
            search(pick_key());

        while (issued < TARGET_ITEMS)
            random_phase();

        wait_idle();
        repeat (20) @(posedge clk);
        if (errors == 0 && outstanding == 0)
            $display("PASS rotated_sorted_table_search");
        else
            $display("FAIL rotated_sorted_table_search");
        $finish;
    end

endmodule
